@@ src/bam_pkg.sv @@
// ----------------------------------------------------------------------------
// bam_pkg
// Shared types and constants of the block-average mosaic.
// ----------------------------------------------------------------------------
package bam_pkg;
    localparam int MAX_WIDTH = 2048;
    localparam int MAX_BLOCK = 32;
    localparam int SUM_MAX   = MAX_BLOCK * MAX_BLOCK * 255;
    localparam int SUM_W     = $clog2(SUM_MAX + 1);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 12;
    localparam int BS_W      = 6;
    localparam int CIT_W     = $clog2(MAX_BLOCK);
    localparam int AREA_W    = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
    localparam int QDEPTH    = 2;
    localparam int CNT_W     = $clog2(SUM_W);

    localparam logic [1:0] REG_BLOCK_SIZE  = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH = 2'd1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } t_pix;

    typedef struct packed {
        logic [7:0]  avg_red;
        logic [7:0]  avg_green;
        logic [7:0]  avg_blue;
        logic [10:0] tile_x;
        logic [10:0] tile_y;
    } t_res;

    typedef struct packed {
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [COL_W-1:0]  tile;
        logic [10:0]       tile_row;
        logic              first;
        logic              last;
        logic [AREA_W-1:0] area;
    } t_job;

    typedef enum logic [1:0] {BS_IDLE, BS_RD, BS_DIV, BS_PUT} t_bstate;
endpackage

@@ src/bam_ram.sv @@
// ----------------------------------------------------------------------------
// bam_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module bam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/bam_front.sv @@
// ----------------------------------------------------------------------------
// bam_front
// Raster position tracking and tile classification of each pixel.
// ----------------------------------------------------------------------------
module bam_front import bam_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_pix             i_pix,
    input  logic [BS_W-1:0]  i_bs,
    input  logic [WID_W-1:0] i_w,
    output logic             o_push,
    output t_job             o_job
);
    logic [COL_W-1:0] r_pc, r_tc, r_tr, n_pc, n_tc, n_tr, c_pc, c_tc, c_tr;
    logic [CIT_W-1:0] r_cit, r_rit, n_cit, n_rit, c_cit, c_rit;
    logic [17:0]      span;
    logic [11:0]      sq;
    logic             in_tile;

    always_comb begin
        c_pc  = i_pix.frame_start ? '0 : r_pc;
        c_tc  = i_pix.frame_start ? '0 : r_tc;
        c_tr  = i_pix.frame_start ? '0 : r_tr;
        c_cit = i_pix.frame_start ? '0 : r_cit;
        c_rit = i_pix.frame_start ? '0 : r_rit;
        span    = ({7'b0, c_tc} + 18'd1) * {12'b0, i_bs};
        in_tile = span <= 18'(i_w);
        sq      = {6'b0, i_bs} * {6'b0, i_bs};

        n_pc = c_pc; n_tc = c_tc; n_tr = c_tr; n_cit = c_cit; n_rit = c_rit;
        if ({1'b0, c_pc} + 12'd1 >= i_w) begin
            n_pc = '0; n_cit = '0; n_tc = '0;
            if ({1'b0, c_rit} + 6'd1 >= i_bs) begin
                n_rit = '0;
                n_tr  = c_tr + 1'b1;
            end else begin
                n_rit = c_rit + 1'b1;
            end
        end else begin
            n_pc = c_pc + 1'b1;
            if ({1'b0, c_cit} + 6'd1 >= i_bs) begin
                n_cit = '0;
                n_tc  = c_tc + 1'b1;
            end else begin
                n_cit = c_cit + 1'b1;
            end
        end

        o_job.red      = i_pix.red;
        o_job.green    = i_pix.green;
        o_job.blue     = i_pix.blue;
        o_job.tile     = c_tc;
        o_job.tile_row = c_tr;
        o_job.first    = (c_rit == '0) && (c_cit == '0);
        o_job.last     = ({1'b0, c_rit} == i_bs - 6'd1) && ({1'b0, c_cit} == i_bs - 6'd1);
        o_job.area     = sq[AREA_W-1:0];
        o_push         = i_accept && in_tile;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0; r_tc <= '0; r_tr <= '0; r_cit <= '0; r_rit <= '0;
        end else if (i_accept) begin
            r_pc <= n_pc; r_tc <= n_tc; r_tr <= n_tr; r_cit <= n_cit; r_rit <= n_rit;
        end
    end
endmodule

@@ src/bam_queue.sv @@
// ----------------------------------------------------------------------------
// bam_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module bam_queue import bam_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);
    localparam int PW = $clog2(QDEPTH);

    t_job            r_buf [QDEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    assign o_full  = r_cnt == (PW+1)'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end
endmodule

@@ src/bam_back.sv @@
// ----------------------------------------------------------------------------
// bam_back
// Column sum update in RAM and tile mean by serial division.
// ----------------------------------------------------------------------------
module bam_back import bam_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_job i_job,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);
    t_bstate            r_state, n_state;
    t_job               r_job;
    logic [3*SUM_W-1:0] rdata, wdata;
    logic [SUM_W-1:0]   r_num [3];
    logic [AREA_W-1:0]  r_rem [3];
    logic [SUM_W-1:0]   sum [3];
    logic [AREA_W:0]    rem_sh [3];
    logic [2:0]         ge;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_oval;
    t_res               r_res;
    logic [7:0]         pv [3];
    logic [7:0]         q8 [3];
    logic               we, load_out;

    bam_ram #(.WIDTH(3*SUM_W), .DEPTH(MAX_WIDTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_job.tile),
        .i_wdata(wdata),
        .i_re   (o_pop),
        .i_raddr(i_job.tile),
        .o_rdata(rdata)
    );

    always_comb begin
        pv[0] = r_job.red; pv[1] = r_job.green; pv[2] = r_job.blue;
        for (int k = 0; k < 3; k++) begin
            logic [SUM_W:0] s;
            s = {1'b0, rdata[(2-k)*SUM_W +: SUM_W]} + (SUM_W+1)'(pv[k]);
            if (r_job.first) begin
                sum[k] = SUM_W'(pv[k]);
            end else begin
                sum[k] = (s > (SUM_W+1)'(SUM_MAX)) ? SUM_W'(SUM_MAX) : s[SUM_W-1:0];
            end
            rem_sh[k] = {r_rem[k], r_num[k][SUM_W-1]};
            ge[k]     = rem_sh[k] >= {1'b0, r_job.area};
            q8[k]     = (r_num[k][SUM_W-1:8] != '0) ? 8'hFF : r_num[k][7:0];
        end
        wdata = {sum[0], sum[1], sum[2]};
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        we       = 1'b0;
        load_out = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = BS_RD;
                end
            end
            BS_RD: begin
                we      = 1'b1;
                n_state = r_job.last ? BS_DIV : BS_IDLE;
            end
            BS_DIV: begin
                if (r_cnt == '0) n_state = BS_PUT;
            end
            BS_PUT: begin
                if (!r_oval || i_ready) begin
                    load_out = 1'b1;
                    n_state  = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out)     r_oval <= 1'b1;
            else if (i_ready) r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (we) begin
            r_cnt <= CNT_W'(SUM_W - 1);
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= sum[k];
                r_rem[k] <= '0;
            end
        end else if (r_state == BS_DIV) begin
            r_cnt <= r_cnt - 1'b1;
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= {r_num[k][SUM_W-2:0], ge[k]};
                r_rem[k] <= ge[k] ? AREA_W'(rem_sh[k] - {1'b0, r_job.area})
                                  : rem_sh[k][AREA_W-1:0];
            end
        end
        if (load_out) begin
            r_res.avg_red   <= q8[0];
            r_res.avg_green <= q8[1];
            r_res.avg_blue  <= q8[2];
            r_res.tile_x    <= r_job.tile;
            r_res.tile_y    <= r_job.tile_row;
        end
    end

    assign o_valid = r_oval;
    assign o_res   = r_res;
endmodule

@@ src/block_average_mosaic.sv @@
// ----------------------------------------------------------------------------
// block_average_mosaic
// Block-average mosaic over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels are accepted at one per clock while the two-entry job queue has
// room; pixels that fall in partial tiles at the right edge are dropped at
// once. For each kept pixel the back end pops the job and reads the column
// sum RAM in its idle state and writes the updated sum in its read state;
// the last tile pixel then runs a serial division of its 18-bit sums
// and loads the result register before the back end takes a new job.
// ----------------------------------------------------------------------------
module block_average_mosaic import bam_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_pix        i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_res        o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);
    logic [BS_W-1:0]  r_bs, bs;
    logic [WID_W-1:0] r_w, w;
    logic             push, full, empty, pop, accept;
    t_job             fjob, qjob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs <= BS_W'(10);
            r_w  <= WID_W'(640);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BLOCK_SIZE:  r_bs <= i_cfg_data[BS_W-1:0];
                REG_IMAGE_WIDTH: r_w  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        bs = (r_bs == '0) ? BS_W'(1) : (r_bs > BS_W'(MAX_BLOCK)) ? BS_W'(MAX_BLOCK) : r_bs;
        w  = (r_w == '0) ? WID_W'(1) : (r_w > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : r_w;
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !full;
    assign accept      = i_in_valid && !full;

    bam_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_pix   (i_in),
        .i_bs    (bs),
        .i_w     (w),
        .o_push  (push),
        .o_job   (fjob)
    );

    bam_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (fjob),
        .i_pop  (pop),
        .o_full (full),
        .o_empty(empty),
        .o_job  (qjob)
    );

    bam_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(empty),
        .i_job  (qjob),
        .o_pop  (pop),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_res  (o_out)
    );
endmodule

@@ tb/mosaic_checker.sv @@
// ----------------------------------------------------------------------------
// mosaic_checker
// Watches the pixel, tile and register channels of the mosaic block, keeps
// its own copy of the tile sums and raster counters, predicts each tile
// average and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module mosaic_checker import bam_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_pix        i_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_res        i_out,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_tiles
);
    localparam int SUM_LIMIT = MAX_BLOCK * MAX_BLOCK * 255;

    logic [5:0]  block_size_q;
    logic [11:0] width_q;
    int          sum_r [MAX_WIDTH];
    int          sum_g [MAX_WIDTH];
    int          sum_b [MAX_WIDTH];
    int          pix_col, col_in_tile, row_in_tile, tile_col, tile_row;
    t_res        tile_queue [$];

    function automatic int sat(input int a, input int b);
        return (a + b > SUM_LIMIT) ? SUM_LIMIT : a + b;
    endfunction

    function automatic logic [7:0] mean(input int sum, input int area);
        return (sum / area > 255) ? 8'd255 : 8'(sum / area);
    endfunction

    task automatic predict_tile(input t_pix px);
        int   bs, w, t, area;
        t_res res;
        bs = (block_size_q == 0) ? 1 : (block_size_q > MAX_BLOCK ? MAX_BLOCK : block_size_q);
        w  = (width_q == 0) ? 1 : (width_q > MAX_WIDTH ? MAX_WIDTH : width_q);
        if (px.frame_start) begin
            pix_col = 0; col_in_tile = 0; row_in_tile = 0; tile_col = 0; tile_row = 0;
        end
        if (tile_col < w / bs) begin
            t = tile_col;
            if (row_in_tile == 0 && col_in_tile == 0) begin
                sum_r[t] = px.red; sum_g[t] = px.green; sum_b[t] = px.blue;
            end else begin
                sum_r[t] = sat(sum_r[t], px.red);
                sum_g[t] = sat(sum_g[t], px.green);
                sum_b[t] = sat(sum_b[t], px.blue);
            end
            if (row_in_tile == bs - 1 && col_in_tile == bs - 1) begin
                area = bs * bs;
                res.avg_red   = mean(sum_r[t], area);
                res.avg_green = mean(sum_g[t], area);
                res.avg_blue  = mean(sum_b[t], area);
                res.tile_x    = 11'(t);
                res.tile_y    = 11'(tile_row);
                tile_queue.push_back(res);
            end
        end
        if (pix_col + 1 >= w) begin
            pix_col = 0; col_in_tile = 0; tile_col = 0;
            if (row_in_tile + 1 >= bs) begin
                row_in_tile = 0;
                tile_row = (tile_row + 1) & 'h7FF;
            end else begin
                row_in_tile++;
            end
        end else begin
            pix_col++;
            if (col_in_tile + 1 >= bs) begin
                col_in_tile = 0;
                tile_col++;
            end else begin
                col_in_tile++;
            end
        end
    endtask

    task automatic compare_tile(input t_res got);
        t_res exp_res;
        if (tile_queue.size() == 0) begin
            $error("unexpected tile result %p", got);
            o_errors++;
            return;
        end
        exp_res = tile_queue.pop_front();
        o_tiles++;
        if (got.avg_red !== exp_res.avg_red) begin
            $error("avg_red expected %0d actual %0d", exp_res.avg_red, got.avg_red);
            o_errors++;
        end
        if (got.avg_green !== exp_res.avg_green) begin
            $error("avg_green expected %0d actual %0d", exp_res.avg_green, got.avg_green);
            o_errors++;
        end
        if (got.avg_blue !== exp_res.avg_blue) begin
            $error("avg_blue expected %0d actual %0d", exp_res.avg_blue, got.avg_blue);
            o_errors++;
        end
        if (got.tile_x !== exp_res.tile_x) begin
            $error("tile_x expected %0d actual %0d", exp_res.tile_x, got.tile_x);
            o_errors++;
        end
        if (got.tile_y !== exp_res.tile_y) begin
            $error("tile_y expected %0d actual %0d", exp_res.tile_y, got.tile_y);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_tiles  = 0;
    end

    assign o_pending = tile_queue.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            block_size_q <= 6'd10;
            width_q      <= 12'd640;
            pix_col = 0; col_in_tile = 0; row_in_tile = 0; tile_col = 0; tile_row = 0;
            tile_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                compare_tile(i_out);
            end
            if (i_in_valid && i_in_ready) begin
                predict_tile(i_in);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_BLOCK_SIZE) begin
                    block_size_q <= i_cfg_data[5:0];
                end else if (i_cfg_index == REG_IMAGE_WIDTH) begin
                    width_q <= i_cfg_data;
                end
            end
        end
    end
endmodule

@@ tb/tb_block_average_mosaic.sv @@
// ----------------------------------------------------------------------------
// tb_block_average_mosaic
// Drives raster frames through the mosaic block over several tile sizes and
// line widths, with bursty input, a stalling output and a long output hold.
// ----------------------------------------------------------------------------
module tb_block_average_mosaic;
    import bam_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_pix        i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_res        o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [11:0] i_cfg_data;
    int          errors;
    int          pending;
    int          tiles;
    int          cycles;
    int          pixels_sent;
    int          hold_off;
    bit          random_gaps;
    bit          done;

    block_average_mosaic DUT (.*);

    mosaic_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_tiles     (tiles)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in = '0; i_out_ready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = REG_BLOCK_SIZE; i_cfg_data = '0;
        hold_off = 0; random_gaps = 1'b0; done = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_block_average_mosaic failed");
            $finish;
        end
    end
    initial cycles = 0;

    // Receiver: random stalls, with long holds on request.
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off    <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else if (random_gaps) begin
            i_out_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_pixel(input t_pix px);
        if (random_gaps && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in       <= px;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Frame of random pixels, optionally with extreme values.
    task automatic send_frame(input int lines, input int width, input int mode);
        t_pix px;
        for (int y = 0; y < lines; y++) begin
            for (int x = 0; x < width; x++) begin
                px.red   = mode == 1 ? 8'hFF : mode == 2 ? 8'h00 : 8'($urandom);
                px.green = mode == 1 ? 8'hFF : mode == 2 ? 8'h00 : 8'($urandom);
                px.blue  = mode == 1 ? 8'hFF : mode == 2 ? 8'h00 : 8'($urandom);
                px.frame_start = (x == 0 && y == 0);
                send_pixel(px);
            end
        end
    endtask

    task automatic configure(input int bs, input int w);
        drain();
        write_reg(REG_BLOCK_SIZE, 12'(bs));
        write_reg(REG_IMAGE_WIDTH, 12'(w));
    endtask

    initial begin
        int bs, w;
        t_pix px;
        pixels_sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: smallest tiles, full-scale white, black, frame restart.
        configure(1, 3);
        send_frame(1, 3, 1);
        send_frame(1, 3, 2);
        configure(2, 5);
        send_frame(2, 5, 1);
        px = '{8'h80, 8'h01, 8'hFE, 1'b1};
        send_pixel(px);
        send_frame(2, 4, 0);

        // Hold the output for a long stretch while the input keeps offering.
        random_gaps = 1'b1;
        configure(1, 40);
        hold_off = 400;
        send_frame(1, 40, 0);
        drain();

        // Random phases, including the extreme sizes.
        while (pixels_sent < 1850) begin
            case ($urandom_range(0, 5))
                0: begin bs = 32; w = 32 + $urandom_range(0, 8); end
                1: begin bs = 1;  w = $urandom_range(1, 30); end
                2: begin bs = 2;  w = 2048; end
                3: begin bs = 0;  w = $urandom_range(1, 12); end
                default: begin bs = $urandom_range(2, 6); w = $urandom_range(1, 30); end
            endcase
            if (pixels_sent > 500 && bs == 32) bs = 3;
            random_gaps = $urandom_range(0, 3) != 0;
            configure(bs, w);
            if (bs == 2 && w == 2048) begin
                send_frame(1, 300, 0);
            end else if (bs == 32) begin
                send_frame(32, w, $urandom_range(0, 2));
            end else begin
                send_frame($urandom_range(1, 2) * (bs == 0 ? 1 : bs), w, 0);
            end
        end
        drain();
        write_reg(REG_IMAGE_WIDTH, 12'd4095);
        write_reg(REG_BLOCK_SIZE, 12'd63);
        random_gaps = 1'b0;
        send_frame(32, 3, 0);
        drain();
        done = 1'b1;
    end

    always @(posedge i_clk) begin
        if (done) begin
            $display("pixels sent %0d, tiles checked %0d, tile sizes 1 to 32",
                     pixels_sent, tiles);
            if (errors == 0) begin
                $display("tb_block_average_mosaic passed");
            end else begin
                $display("tb_block_average_mosaic failed");
            end
            $finish;
        end
    end
endmodule

@@ filelist.f @@
src/bam_pkg.sv
src/bam_ram.sv
src/bam_front.sv
src/bam_queue.sv
src/bam_back.sv
src/block_average_mosaic.sv
tb/mosaic_checker.sv
tb/tb_block_average_mosaic.sv
